// ===== rtl/core/cc20_pkg.sv =====
package cc20_pkg;

    localparam int NUM_WORDS           = 16;
    localparam int ROW_LEN             = 4;
    localparam int DOUBLE_ROUNDS_DEF   = 10;
    localparam int QR_PER_DOUBLE_ROUND = 8;
    localparam int CFG_INDEX_W         = 3;
    localparam int CFG_DATA_W          = 64;

    typedef logic [31:0] word_t;
    typedef word_t [NUM_WORDS-1:0] words_t;

    // "expand 32-byte k", little-endian words
    localparam word_t SIGMA_0 = 32'h61707865;
    localparam word_t SIGMA_1 = 32'h3320646e;
    localparam word_t SIGMA_2 = 32'h79622d32;
    localparam word_t SIGMA_3 = 32'h6b206574;

    // quarter-round step index inside one quarter round
    typedef logic [1:0] qr_step_t;
    localparam qr_step_t STEP_LAST = 2'd3;

    typedef enum logic [2:0] {
        CFG_KEY_0_7   = 3'd0,
        CFG_KEY_8_15  = 3'd1,
        CFG_KEY_16_23 = 3'd2,
        CFG_KEY_24_31 = 3'd3,
        CFG_NONCE_0_7 = 3'd4,
        CFG_NONCE_8_11 = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PERM_NONE,
        PERM_ROT,
        PERM_ROT_DIAG,
        PERM_ROT_UNDIAG
    } perm_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_ADD,
        S_EMIT
    } seq_state_t;

    typedef struct packed {
        logic     idle;
        logic     round_en;
        qr_step_t step;
        perm_t    perm;
        logic     add_en;
        logic [3:0] add_idx;
        logic     add_last;
        logic     emit_en;
    } seq_ctrl_t;

    // rotate every row of the 4x4 matrix left; the amount per row follows the mode
    function automatic words_t perm_words(input words_t w, input perm_t mode);
        words_t     res;
        logic [1:0] amt;
        logic [1:0] col;
        for (int r = 0; r < ROW_LEN; r++) begin
            unique case (mode)
                PERM_NONE:       amt = 2'd0;
                PERM_ROT:        amt = 2'd1;
                PERM_ROT_DIAG:   amt = 2'(1 + r);
                PERM_ROT_UNDIAG: amt = 2'(1 + ROW_LEN - r);
                default:         amt = 2'd0;
            endcase
            for (int c = 0; c < ROW_LEN; c++) begin
                col = 2'(c) + amt;
                res[r*ROW_LEN + c] = w[r*ROW_LEN + int'(col)];
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/cc20_alu.sv =====
module cc20_alu
    import cc20_pkg::*;
(
    input  word_t    x,
    input  word_t    y,
    input  word_t    z,
    input  qr_step_t step,
    output word_t    sum,
    output word_t    rot
);

    word_t mix;

    assign sum = x + y;
    assign mix = z ^ sum;

    // rotate amounts 16, 12, 8, 7 by step
    always_comb begin
        unique case (step)
            2'd0:    rot = {mix[15:0], mix[31:16]};
            2'd1:    rot = {mix[19:0], mix[31:20]};
            2'd2:    rot = {mix[23:0], mix[31:24]};
            default: rot = {mix[24:0], mix[31:25]};
        endcase
    end

endmodule

// ===== rtl/core/cc20_seq.sv =====
module cc20_seq
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  logic      out_free,
    output seq_ctrl_t ctrl
);

    localparam int DR_W = $clog2(DOUBLE_ROUNDS + 1);
    localparam logic [DR_W-1:0] DR_LAST = DR_W'(DOUBLE_ROUNDS - 1);
    localparam logic [2:0] QR_LAST = 3'(QR_PER_DOUBLE_ROUND - 1);
    localparam logic [2:0] QR_MID  = 3'(QR_PER_DOUBLE_ROUND / 2 - 1);

    seq_state_t      state_reg, state_next;
    qr_step_t        step_reg, step_next;
    logic [2:0]      qr_reg, qr_next;
    logic [DR_W-1:0] dr_reg, dr_next;
    logic [3:0]      add_reg, add_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            qr_reg    <= '0;
            dr_reg    <= '0;
            add_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            qr_reg    <= qr_next;
            dr_reg    <= dr_next;
            add_reg   <= add_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        qr_next    = qr_reg;
        dr_next    = dr_reg;
        add_next   = add_reg;
        ctrl       = '0;
        ctrl.step  = step_reg;
        ctrl.add_idx = add_reg;
        unique case (state_reg)
            S_IDLE: begin
                ctrl.idle = 1'b1;
                if (start) begin
                    state_next = S_ROUND;
                    step_next  = '0;
                    qr_next    = '0;
                    dr_next    = '0;
                end
            end
            S_ROUND: begin
                ctrl.round_en = 1'b1;
                step_next     = step_reg + 2'd1;
                if (step_reg == STEP_LAST) begin
                    if (qr_reg == QR_MID) begin
                        ctrl.perm = PERM_ROT_DIAG;
                    end else if (qr_reg == QR_LAST) begin
                        ctrl.perm = PERM_ROT_UNDIAG;
                    end else begin
                        ctrl.perm = PERM_ROT;
                    end
                    qr_next = qr_reg + 3'd1;
                    if (qr_reg == QR_LAST) begin
                        dr_next = dr_reg + DR_W'(1);
                        if (dr_reg == DR_LAST) begin
                            state_next = S_ADD;
                            add_next   = '0;
                        end
                    end
                end
            end
            S_ADD: begin
                ctrl.add_en = 1'b1;
                add_next    = add_reg + 4'd1;
                if (add_reg == 4'(NUM_WORDS - 1)) begin
                    ctrl.add_last = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    ctrl.emit_en = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_add_starts_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROUND && state_next == S_ADD) |=> (add_reg == '0))
        else $error("add-back pass does not start at word zero");

    a_round_ends_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROUND && state_next == S_ADD)
            |-> (step_reg == STEP_LAST && qr_reg == QR_LAST))
        else $error("rounds left mid quarter round");

    a_start_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |=> (state_reg != S_ROUND || $past(state_reg) == S_ROUND
                                   || $past(state_reg) == S_IDLE))
        else $error("round phase entered from wrong state");

endmodule

// ===== rtl/core/chacha20_stream_cipher.sv =====
// chacha20 byte-stream cipher, ietf layout (32-bit block counter, 96-bit nonce)
//
// input channel s_*: one item is one byte plus an end-of-message flag; the
// result channel m_* returns that byte xor the next keystream byte, one
// result item for every input item, in order.
// key and nonce are to be written through cfg_wr_en / cfg_index / cfg_wdata only while
// the block is idle, which the block itself does not enforce; they are used from the next keystream block on.
// a byte that falls inside the current keystream block shows up on m_* in the
// cycle after it is accepted, and such bytes can follow each other every cycle
// while m_ready stays high. a byte at block offset 0 first runs the block
// function on one shared quarter-round step unit: DOUBLE_ROUNDS double rounds,
// then the add-back of all 16 words, then the output of the result byte, which
// waits for a free output register.
// s_ready drops while a block is computed and while a result waits on m_*
// with m_ready low; a stalled receiver holds the result and the block.
// reset clears the block counter, the byte position and all key/nonce words.
module chacha20_stream_cipher
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_in,
    input  logic                   s_end_of_message,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_data_out,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    // configuration registers
    logic [63:0] key_reg [4];
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;

    // cipher state
    logic [31:0] counter_reg, counter_next;
    logic [5:0]  pos_reg, pos_next;
    words_t      work_reg, work_next;
    words_t      ks_reg, ks_next;
    words_t      init_words;

    // byte waiting for its keystream block
    logic [7:0]  pend_data_reg;
    logic        pend_eom_reg;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_data_reg, m_data_next;

    seq_ctrl_t   ctrl;
    logic        out_free;
    logic        accept;
    logic        start;
    logic        direct;
    logic        emit;
    logic        emit_eom;
    logic [7:0]  emit_data;
    word_t       ks_word;
    logic [7:0]  ks_byte;
    word_t       alu_x, alu_y, alu_z;
    word_t       alu_sum, alu_rot;
    words_t      work_upd;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = ctrl.idle && out_free;
    assign accept   = s_valid && s_ready;
    assign start    = accept && (pos_reg == '0);
    assign direct   = accept && (pos_reg != '0);
    assign emit     = direct || ctrl.emit_en;

    assign m_valid    = m_valid_reg;
    assign m_data_out = m_data_reg;

    cc20_seq #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    // block function input: constant, key, counter, nonce
    always_comb begin
        init_words[0] = SIGMA_0;
        init_words[1] = SIGMA_1;
        init_words[2] = SIGMA_2;
        init_words[3] = SIGMA_3;
        for (int i = 0; i < 4; i++) begin
            init_words[4 + 2*i] = key_reg[i][31:0];
            init_words[5 + 2*i] = key_reg[i][63:32];
        end
        init_words[12] = counter_reg;
        init_words[13] = nonce_lo_reg[31:0];
        init_words[14] = nonce_lo_reg[63:32];
        init_words[15] = nonce_hi_reg;
    end

    // the step unit always works on column 0 (words 0, 4, 8, 12);
    // even steps update a and d, odd steps c and b
    always_comb begin
        if (ctrl.add_en) begin
            alu_x = work_reg[0];
            alu_y = init_words[ctrl.add_idx];
            alu_z = work_reg[12];
        end else if (ctrl.step[0]) begin
            alu_x = work_reg[8];
            alu_y = work_reg[12];
            alu_z = work_reg[4];
        end else begin
            alu_x = work_reg[0];
            alu_y = work_reg[4];
            alu_z = work_reg[12];
        end
    end

    cc20_alu u_alu (
        .x    (alu_x),
        .y    (alu_y),
        .z    (alu_z),
        .step (ctrl.step),
        .sum  (alu_sum),
        .rot  (alu_rot)
    );

    always_comb begin
        work_upd = work_reg;
        if (ctrl.step[0]) begin
            work_upd[8] = alu_sum;
            work_upd[4] = alu_rot;
        end else begin
            work_upd[0]  = alu_sum;
            work_upd[12] = alu_rot;
        end

        work_next = work_reg;
        ks_next   = ks_reg;
        if (start) begin
            work_next = init_words;
        end else if (ctrl.round_en) begin
            // after each quarter round the next column rotates into place;
            // the mid and last rotations also enter and leave the diagonal layout
            work_next = perm_words(work_upd, ctrl.perm);
        end else if (ctrl.add_en) begin
            // add-back: words leave at word 0 and the keystream fills from the top
            work_next = {work_reg[0], work_reg[NUM_WORDS-1:1]};
            ks_next   = {alu_sum, ks_reg[NUM_WORDS-1:1]};
        end
    end

    // keystream byte for the current position
    assign ks_word   = ks_reg[pos_reg[5:2]];
    assign ks_byte   = ks_word[{pos_reg[1:0], 3'b000} +: 8];
    assign emit_data = ctrl.emit_en ? pend_data_reg : s_data_in;
    assign emit_eom  = ctrl.emit_en ? pend_eom_reg : s_end_of_message;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        pos_next     = pos_reg;
        counter_next = counter_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (ctrl.add_last) begin
            counter_next = counter_reg + 32'd1;
        end
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_data ^ ks_byte;
            if (emit_eom) begin
                pos_next     = '0;
                counter_next = '0;
            end else begin
                pos_next = pos_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg  <= '0;
            pos_reg      <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= '0;
            end
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
        end else begin
            counter_reg <= counter_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                // indexes past the nonce are dropped
                unique case (cfg_index)
                    CFG_KEY_0_7:    key_reg[0]   <= cfg_wdata;
                    CFG_KEY_8_15:   key_reg[1]   <= cfg_wdata;
                    CFG_KEY_16_23:  key_reg[2]   <= cfg_wdata;
                    CFG_KEY_24_31:  key_reg[3]   <= cfg_wdata;
                    CFG_NONCE_0_7:  nonce_lo_reg <= cfg_wdata;
                    CFG_NONCE_8_11: nonce_hi_reg <= cfg_wdata[31:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        work_reg   <= work_next;
        ks_reg     <= ks_next;
        m_data_reg <= m_data_next;
        if (start) begin
            pend_data_reg <= s_data_in;
            pend_eom_reg  <= s_end_of_message;
        end
    end

    a_direct_result: assert property (@(posedge aclk) disable iff (!aresetn)
        direct |=> m_valid_reg)
        else $error("byte inside a block produced no result");

    a_pos_moves_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !emit |=> $stable(pos_reg))
        else $error("byte position moved without a result");

    a_counter_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        !(emit || ctrl.add_last) |=> $stable(counter_reg))
        else $error("block counter moved outside block end or message end");

endmodule

// ===== sim/chacha20_stream_cipher_test.sv =====
`timescale 1ns / 100ps

module chacha20_stream_cipher_test;
    import cc20_pkg::*;

    // cycles without any item moving before the run is declared hung
    localparam int QUIET_LIMIT = 5000;
    // settle time after the last result before a key/nonce write or the end
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 40;
    // random items per idling phase
    localparam int PHASE_ITEMS   = 320;

    // indexes past the register file, the block must ignore them
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_7 = 3'd7;

    localparam logic [CFG_DATA_W-1:0] ALL_ZEROS = '0;
    localparam logic [CFG_DATA_W-1:0] ALL_ONES  = '1;

    // keystream predictor plus queue of expected output bytes
    class keystream_scoreboard;
        logic [CFG_DATA_W-1:0] key_nonce [6];
        word_t                 block_count;
        logic [5:0]            byte_pos;
        words_t                keystream;
        logic [7:0]            expected_bytes [$];
        int                    errors;

        function new();
            foreach (key_nonce[i]) key_nonce[i] = '0;
            block_count = '0;
            byte_pos    = '0;
            keystream   = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_KEY_0_7, CFG_KEY_8_15, CFG_KEY_16_23, CFG_KEY_24_31, CFG_NONCE_0_7:
                    key_nonce[idx] = value;
                CFG_NONCE_8_11: key_nonce[idx] = {32'h0, value[31:0]};
                default: ;
            endcase
        endfunction

        function word_t rotl(word_t x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void quarter_round(inout words_t w, input int a, int b, int c, int d);
            w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
            w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
            w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
            w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
        endfunction

        function void next_block();
            words_t start;
            words_t work;
            start[0] = SIGMA_0;
            start[1] = SIGMA_1;
            start[2] = SIGMA_2;
            start[3] = SIGMA_3;
            for (int i = 0; i < 4; i++) begin
                start[4 + 2*i] = key_nonce[i][31:0];
                start[5 + 2*i] = key_nonce[i][63:32];
            end
            start[12] = block_count;
            start[13] = key_nonce[CFG_NONCE_0_7][31:0];
            start[14] = key_nonce[CFG_NONCE_0_7][63:32];
            start[15] = key_nonce[CFG_NONCE_8_11][31:0];
            work = start;
            for (int r = 0; r < DOUBLE_ROUNDS_DEF; r++) begin
                quarter_round(work, 0, 4, 8, 12);
                quarter_round(work, 1, 5, 9, 13);
                quarter_round(work, 2, 6, 10, 14);
                quarter_round(work, 3, 7, 11, 15);
                quarter_round(work, 0, 5, 10, 15);
                quarter_round(work, 1, 6, 11, 12);
                quarter_round(work, 2, 7, 8, 13);
                quarter_round(work, 3, 4, 9, 14);
            end
            for (int i = 0; i < NUM_WORDS; i++)
                keystream[i] = work[i] + start[i];
            block_count = block_count + 32'd1;
        endfunction

        function void note_byte(logic [7:0] data, logic last);
            word_t      w;
            logic [7:0] ks_byte;
            if (byte_pos == 6'd0)
                next_block();
            w       = keystream[byte_pos[5:2]];
            ks_byte = 8'(w >> {byte_pos[1:0], 3'b000});
            expected_bytes.push_back(data ^ ks_byte);
            byte_pos = byte_pos + 6'd1;
            if (last) begin
                block_count = '0;
                byte_pos    = '0;
            end
        endfunction

        function void check_byte(logic [7:0] actual);
            logic [7:0] want;
            if (expected_bytes.size() == 0) begin
                $display("%0t: data_out expected none, actual %02h", $time, actual);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (actual !== want) begin
                    $display("%0t: data_out expected %02h, actual %02h", $time, want, actual);
                    errors++;
                end
            end
        endfunction

        function void wrap_up();
            if (expected_bytes.size() != 0) begin
                $display("%0t: %0d output bytes expected, actual none",
                         $time, expected_bytes.size());
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [7:0]             s_data_in;
    logic                   s_end_of_message;
    logic                   m_valid;
    logic                   m_ready;
    logic [7:0]             m_data_out;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    keystream_scoreboard sb;

    // idling odds of the current phase, in percent
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // bytes handed over by the sender and bytes taken on m_*
    int n_sent      = 0;
    int n_recv      = 0;
    int quiet_count = 0;

    chacha20_stream_cipher #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS_DEF)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_in       (s_data_in),
        .s_end_of_message(s_end_of_message),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_out      (m_data_out),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // receiver: random back-pressure at the odds of the phase
    initial m_ready = 1'b0;
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: handshakes are seen with the values from before the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_byte(s_data_in, s_end_of_message);
            if (m_valid && m_ready) begin
                sb.check_byte(m_data_out);
                n_recv++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_count = 0;
            else
                quiet_count++;
        end
    end

    // watchdog: nothing moving for too long means a hung block
    initial begin
        while (quiet_count < QUIET_LIMIT) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    // offer one item, idling first at the phase odds; returns once accepted
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_data_in        <= data;
        s_end_of_message <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    // stop offering and wait until every byte has come back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (n_recv != n_sent) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one register write; the caller lowers the enable after a batch
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.write_reg(idx, value);
        @(posedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_reg_value();
        case ($urandom_range(9))
            0:       return ALL_ZEROS;
            1:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // new key and nonce, sometimes with a stray write to an unused index
    task automatic random_config();
        cfg_write(CFG_KEY_0_7,    random_reg_value());
        cfg_write(CFG_KEY_8_15,   random_reg_value());
        cfg_write(CFG_KEY_16_23,  random_reg_value());
        cfg_write(CFG_KEY_24_31,  random_reg_value());
        cfg_write(CFG_NONCE_0_7,  random_reg_value());
        cfg_write(CFG_NONCE_8_11, random_reg_value());
        if ($urandom_range(3) == 0)
            cfg_write($urandom_range(1) ? CFG_UNUSED_6 : CFG_UNUSED_7, random_reg_value());
        cfg_wr_en <= 1'b0;
    endtask

    // mostly whole messages of varied length, some with loose end marks
    task automatic random_traffic(input int count);
        int goal;
        int len;
        int pick;
        bit noisy;
        goal = n_sent + count;
        while (n_sent < goal) begin
            noisy = ($urandom_range(4) == 0);
            pick  = $urandom_range(99);
            if (noisy)          len = $urandom_range(20, 1);
            else if (pick < 40) len = $urandom_range(8, 1);
            else if (pick < 75) len = $urandom_range(70, 9);
            else if (pick < 90) len = $urandom_range(65, 63);
            else                len = $urandom_range(200, 100);
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom_range(255)),
                          noisy ? 1'($urandom_range(1)) : (i == len - 1));
        end
    endtask

    initial begin
        sb               = new();
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_data_in        <= '0;
        s_end_of_message <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_index        <= '0;
        cfg_wdata        <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset key and nonce, short message then one-byte messages
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h5a, 1'b1);
        send_byte(8'ha5, 1'b1);
        send_byte(8'h5a, 1'b1);
        wait_for_results();

        // all-ones key and nonce; upper half of the last nonce word must be dropped,
        // unused indexes must not disturb anything
        cfg_write(CFG_KEY_0_7,    ALL_ONES);
        cfg_write(CFG_KEY_8_15,   ALL_ONES);
        cfg_write(CFG_KEY_16_23,  ALL_ONES);
        cfg_write(CFG_KEY_24_31,  ALL_ONES);
        cfg_write(CFG_NONCE_0_7,  ALL_ONES);
        cfg_write(CFG_NONCE_8_11, ALL_ONES);
        cfg_write(CFG_UNUSED_6,   ALL_ZEROS);
        cfg_write(CFG_UNUSED_7,   {$urandom, $urandom});
        cfg_wr_en <= 1'b0;
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        wait_for_results();

        // counting key bytes and a nonce with sparse bytes set
        cfg_write(CFG_KEY_0_7,    64'h0706050403020100);
        cfg_write(CFG_KEY_8_15,   64'h0f0e0d0c0b0a0908);
        cfg_write(CFG_KEY_16_23,  64'h1716151413121110);
        cfg_write(CFG_KEY_24_31,  64'h1f1e1d1c1b1a1918);
        cfg_write(CFG_NONCE_0_7,  64'h4a00000009000000);
        cfg_write(CFG_NONCE_8_11, ALL_ZEROS);
        cfg_wr_en <= 1'b0;
        for (int i = 0; i < 12; i++)
            send_byte(8'(i * 23), (i == 11));
        wait_for_results();

        // random phases, new key and nonce before each
        random_config();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_traffic(PHASE_ITEMS);
        wait_for_results();

        random_config();
        send_idle_pct  = 71;
        recv_stall_pct = 0;
        random_traffic(PHASE_ITEMS);
        wait_for_results();

        random_config();
        send_idle_pct  = 0;
        recv_stall_pct = 71;
        random_traffic(PHASE_ITEMS);
        wait_for_results();

        random_config();
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        random_traffic(PHASE_ITEMS);
        wait_for_results();

        repeat (END_CYCLES) @(posedge aclk);
        sb.wrap_up();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/cc20_pkg.sv
rtl/core/cc20_alu.sv
rtl/core/cc20_seq.sv
rtl/core/chacha20_stream_cipher.sv
sim/chacha20_stream_cipher_test.sv
